// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64d_pkg.sv =====
// Types and constants for the base64 stream decoder
package b64d_pkg;

    localparam int CNT_W = 20;
    localparam int LIM_W = 20;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [LIM_W-1:0] LIM_RESET = {LIM_W{1'b1}};

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [5:0] SXT_PLUS  = 6'd62;
    localparam logic [5:0] SXT_SLASH = 6'd63;

    // slot order: first byte, second byte, third byte, summary record
    localparam int SLOT_B0  = 0;
    localparam int SLOT_B1  = 1;
    localparam int SLOT_B2  = 2;
    localparam int SLOT_SUM = 3;

    typedef struct packed {
        logic [3:0]            mask;
        logic [2:0][7:0]       bytes;
        logic [3:0][CNT_W-1:0] counts;
        logic                  lim_hit;
    } t_bundle;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sxt;

endpackage

// ===== rtl/b64d_if.sv =====
// Channel interfaces: source characters, decoded results, limit register writes
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] in_char;
    logic       end_of_source;

    modport source (output valid, has_char, in_char, end_of_source, input ready);
    modport sink   (input valid, has_char, in_char, end_of_source, output ready);
endinterface

interface b64d_out_if;
    logic                      valid;
    logic                      ready;
    logic                      is_data;
    logic [7:0]                out_byte;
    logic [b64d_pkg::CNT_W-1:0] byte_count;
    logic                      limit_reached;
    logic                      last;

    modport source (output valid, is_data, out_byte, byte_count, limit_reached, last,
                    input ready);
    modport sink   (input valid, is_data, out_byte, byte_count, limit_reached, last,
                    output ready);
endinterface

interface b64d_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [b64d_pkg::LIM_W-1:0] out_limit;

    modport source (output valid, out_limit, input ready);
    modport sink   (input valid, out_limit, output ready);
endinterface

// ===== rtl/b64d_core.sv =====
// Group assembly, limit tracking and result bundle generation
module b64d_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic                       i_has_char,
    input  logic [7:0]                 i_char,
    input  logic                       i_eos,
    input  logic [b64d_pkg::LIM_W-1:0] i_limit,
    output b64d_pkg::t_bundle          o_bundle
);

    logic [23:0]                r_bits, n_bits;
    logic [1:0]                 r_fill, n_fill;
    logic                       r_pad, n_pad;
    logic [b64d_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_stopped, n_stopped;

    b64d_pkg::t_sxt             sx;
    logic [23:0]                gb;
    logic [b64d_pkg::CNT_W-1:0] cnt1, cnt2, cnt3, cnt_new;
    logic                       e0, e1, e2;
    logic [1:0]                 nb;

    function automatic b64d_pkg::t_sxt sextet(input logic [7:0] ch);
        b64d_pkg::t_sxt r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            r.val = 6'(ch - 8'd65);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            r.val = 6'(ch - 8'd71);
        end else if (ch inside {[8'h30:8'h39]}) begin
            r.val = 6'(ch + 8'd4);
        end else if (ch == b64d_pkg::CH_PLUS) begin
            r.val = b64d_pkg::SXT_PLUS;
        end else if (ch == b64d_pkg::CH_SLASH) begin
            r.val = b64d_pkg::SXT_SLASH;
        end else if (ch != b64d_pkg::CH_PAD) begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic room(input logic [b64d_pkg::CNT_W-1:0] x,
                                  input logic [b64d_pkg::LIM_W-1:0] lim);
        return (x < lim) && (x < b64d_pkg::CNT_MAX);
    endfunction

    always_comb begin
        sx   = sextet(i_char);
        gb   = {r_bits[17:0], sx.val};
        cnt1 = r_cnt + b64d_pkg::CNT_W'(1);
        cnt2 = r_cnt + b64d_pkg::CNT_W'(2);
        cnt3 = r_cnt + b64d_pkg::CNT_W'(3);

        n_bits    = r_bits;
        n_fill    = r_fill;
        n_pad     = r_pad;
        n_stopped = r_stopped;
        e0 = 1'b0;
        e1 = 1'b0;
        e2 = 1'b0;

        if (i_has_char && !r_stopped) begin
            if (!room(r_cnt, i_limit)) begin
                n_stopped = 1'b1;
            end else if (sx.ok) begin
                n_bits = gb;
                if (r_fill == 2'd2) begin
                    n_pad = (i_char == b64d_pkg::CH_PAD);
                end
                if (r_fill != 2'd3) begin
                    n_fill = r_fill + 2'd1;
                end else begin
                    e0     = 1'b1;
                    e1     = !r_pad && room(cnt1, i_limit);
                    e2     = (i_char != b64d_pkg::CH_PAD) && room(e1 ? cnt2 : cnt1, i_limit);
                    n_bits = '0;
                    n_fill = '0;
                    n_pad  = 1'b0;
                end
            end
        end

        nb      = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
        cnt_new = r_cnt + b64d_pkg::CNT_W'(nb);
        n_cnt   = cnt_new;
        if (e0 && !room(cnt_new, i_limit)) begin
            n_stopped = 1'b1;
        end

        o_bundle.mask    = {i_eos, e2, e1, e0};
        o_bundle.bytes[b64d_pkg::SLOT_B0]  = gb[23:16];
        o_bundle.bytes[b64d_pkg::SLOT_B1]  = gb[15:8];
        o_bundle.bytes[b64d_pkg::SLOT_B2]  = gb[7:0];
        o_bundle.counts[b64d_pkg::SLOT_B0] = cnt1;
        o_bundle.counts[b64d_pkg::SLOT_B1] = cnt2;
        o_bundle.counts[b64d_pkg::SLOT_B2] = e1 ? cnt3 : cnt2;
        o_bundle.counts[b64d_pkg::SLOT_SUM] = cnt_new;
        o_bundle.lim_hit = (cnt_new == i_limit);

        // end of source: drop partial group, start afresh
        if (i_eos) begin
            n_bits    = '0;
            n_fill    = '0;
            n_pad     = 1'b0;
            n_cnt     = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_fill    <= '0;
            r_pad     <= 1'b0;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
        end else if (i_take) begin
            r_bits    <= n_bits;
            r_fill    <= n_fill;
            r_pad     <= n_pad;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== rtl/b64d_ser.sv =====
// Result register: holds one bundle and sends its slots one transfer at a time
module b64d_ser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  b64d_pkg::t_bundle          i_bundle,
    output logic                       o_free,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic                       o_is_data,
    output logic [7:0]                 o_out_byte,
    output logic [b64d_pkg::CNT_W-1:0] o_byte_count,
    output logic                       o_limit_reached,
    output logic                       o_last
);

    b64d_pkg::t_bundle r_bun;
    logic [3:0]        r_mask, n_mask;
    logic [3:0]        pick;
    logic              xfer;

    always_comb begin
        pick    = r_mask & (~r_mask + 4'd1);
        o_valid = (r_mask != 4'd0);
        o_last  = ((r_mask & ~pick) == 4'd0);
        xfer    = o_valid && i_ready;
        o_free  = !o_valid || (xfer && o_last);

        o_is_data       = 1'b1;
        o_limit_reached = 1'b0;
        o_out_byte      = r_bun.bytes[b64d_pkg::SLOT_B0];
        o_byte_count    = r_bun.counts[b64d_pkg::SLOT_B0];
        case (pick)
            4'b0010: begin
                o_out_byte   = r_bun.bytes[b64d_pkg::SLOT_B1];
                o_byte_count = r_bun.counts[b64d_pkg::SLOT_B1];
            end
            4'b0100: begin
                o_out_byte   = r_bun.bytes[b64d_pkg::SLOT_B2];
                o_byte_count = r_bun.counts[b64d_pkg::SLOT_B2];
            end
            4'b1000: begin
                o_is_data       = 1'b0;
                o_out_byte      = 8'd0;
                o_byte_count    = r_bun.counts[b64d_pkg::SLOT_SUM];
                o_limit_reached = r_bun.lim_hit;
            end
            default: begin
            end
        endcase

        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_bundle.mask;
        end else if (xfer) begin
            n_mask = r_mask & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bun <= i_bundle;
        end
    end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: one source character per transfer, decoded bytes out
// The first result of an item is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle while the result side is ready and each item gives at most one
// result; an item giving several results holds the result register until its last result is taken.
// Reset: synchronous active-low; clears group state, count and result register,
// limit returns to its maximum.
`include "assert_macros.svh"

module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_in_if.sink    i_src,
    b64d_out_if.source o_res,
    b64d_cfg_if.sink   i_cfg
);

    logic [b64d_pkg::LIM_W-1:0] r_limit;
    b64d_pkg::t_bundle          bundle;
    logic                       take;
    logic                       free;

    assign i_cfg.ready = 1'b1;
    assign i_src.ready = free;
    assign take        = i_src.valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= b64d_pkg::LIM_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.out_limit;
        end
    end

    b64d_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_has_char (i_src.has_char),
        .i_char     (i_src.in_char),
        .i_eos      (i_src.end_of_source),
        .i_limit    (r_limit),
        .o_bundle   (bundle)
    );

    b64d_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (take),
        .i_bundle        (bundle),
        .o_free          (free),
        .i_ready         (o_res.ready),
        .o_valid         (o_res.valid),
        .o_is_data       (o_res.is_data),
        .o_out_byte      (o_res.out_byte),
        .o_byte_count    (o_res.byte_count),
        .o_limit_reached (o_res.limit_reached),
        .o_last          (o_res.last)
    );

    `ASSERT_IMP(a_sum_last, i_clk, i_rst_n, o_res.valid && !o_res.is_data, o_res.last, "summary record not last")
    `ASSERT_NXT(a_eos_sum, i_clk, i_rst_n, take && i_src.end_of_source, o_res.valid, "no result after end of source")
    `ASSERT_IMP(a_take_free, i_clk, i_rst_n, take && o_res.valid, o_res.ready && o_res.last, "item taken over pending results")

endmodule

// ===== sim/base64_stream_decoder_checker.sv =====
// Checker for the base64 stream decoder: predicts decoded records and compares each result
module base64_stream_decoder_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    b64d_in_if     i_src,
    b64d_out_if    i_res,
    b64d_cfg_if    i_cfg,
    output int     o_errors,
    output int     o_pending
);

    typedef struct packed {
        logic                       is_data;
        logic [7:0]                 data;
        logic [b64d_pkg::CNT_W-1:0] count;
        logic                       hit;
        logic                       last;
    } t_decoded;

    logic [b64d_pkg::LIM_W-1:0] limit;
    logic [23:0]                grp;
    logic [1:0]                 fill;
    logic                       pad3;
    logic [b64d_pkg::CNT_W-1:0] cnt;
    logic                       halted;

    t_decoded decoded_due[$];
    t_decoded batch[4];
    int       batch_n;
    t_decoded want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic b64d_pkg::t_sxt sextet_of_char(input logic [7:0] c);
        b64d_pkg::t_sxt s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= "A" && c <= "Z") begin
            s.val = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            s.val = 6'(c - "a" + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            s.val = 6'(c - "0" + 8'd52);
        end else if (c == b64d_pkg::CH_PLUS) begin
            s.val = b64d_pkg::SXT_PLUS;
        end else if (c == b64d_pkg::CH_SLASH) begin
            s.val = b64d_pkg::SXT_SLASH;
        end else if (c != b64d_pkg::CH_PAD) begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic logic room_left();
        return (cnt < limit) && (cnt != b64d_pkg::CNT_MAX);
    endfunction

    task automatic put_data(input logic [7:0] v);
        cnt            = cnt + 1'b1;
        batch[batch_n] = '{1'b1, v, cnt, 1'b0, 1'b0};
        batch_n++;
    endtask

    task automatic decode_char(input logic has, input logic [7:0] ch, input logic eos);
        b64d_pkg::t_sxt sx;
        t_decoded       rec;
        int             i;
        batch_n = 0;
        sx      = sextet_of_char(ch);
        if (has && !halted) begin
            if (!room_left()) begin
                halted = 1'b1;
            end else if (sx.ok) begin
                grp = {grp[17:0], sx.val};
                if (fill == 2'd2) begin
                    pad3 = (ch == b64d_pkg::CH_PAD);
                end
                if (fill != 2'd3) begin
                    fill = fill + 1'b1;
                end else begin
                    put_data(grp[23:16]);
                    if (!pad3 && room_left()) begin
                        put_data(grp[15:8]);
                    end
                    if (ch != b64d_pkg::CH_PAD && room_left()) begin
                        put_data(grp[7:0]);
                    end
                    fill = '0;
                    grp  = '0;
                    pad3 = 1'b0;
                    if (!room_left()) begin
                        halted = 1'b1;
                    end
                end
            end
        end
        if (eos) begin
            batch[batch_n] = '{1'b0, 8'h00, cnt, (cnt == limit), 1'b0};
            batch_n++;
            grp    = '0;
            fill   = '0;
            pad3   = 1'b0;
            cnt    = '0;
            halted = 1'b0;
        end
        for (i = 0; i < batch_n; i++) begin
            rec      = batch[i];
            rec.last = (i == batch_n - 1);
            decoded_due.push_back(rec);
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
        $display("%0t: decoder mismatch on %s: got 0x%0h, wanted 0x%0h",
                 $time, field, got, exp_v);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit  = b64d_pkg::LIM_RESET;
            grp    = '0;
            fill   = '0;
            pad3   = 1'b0;
            cnt    = '0;
            halted = 1'b0;
            decoded_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                limit = i_cfg.out_limit;
            end
            // compare first: a transfer in never yields a result in the same cycle
            if (i_res.valid && i_res.ready) begin
                if (decoded_due.size() == 0) begin
                    report("result with none due", 1, 0);
                end else begin
                    want = decoded_due.pop_front();
                    if (i_res.is_data !== want.is_data) begin
                        report("is_data", i_res.is_data, want.is_data);
                    end
                    if (i_res.out_byte !== want.data) begin
                        report("out_byte", i_res.out_byte, want.data);
                    end
                    if (i_res.byte_count !== want.count) begin
                        report("byte_count", i_res.byte_count, want.count);
                    end
                    if (i_res.limit_reached !== want.hit) begin
                        report("limit_reached", i_res.limit_reached, want.hit);
                    end
                    if (i_res.last !== want.last) begin
                        report("last", i_res.last, want.last);
                    end
                end
            end
            if (i_src.valid && i_src.ready) begin
                decode_char(i_src.has_char, i_src.in_char, i_src.end_of_source);
            end
        end
        o_pending = decoded_due.size();
    end

endmodule

// ===== sim/base64_stream_decoder_tb.sv =====
// Testbench top for the base64 stream decoder: reset, stimulus, flow control and verdict
module base64_stream_decoder_tb;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          LONG_HOLD   = 300;

    typedef enum logic [1:0] {END_ON_CHAR, END_EMPTY, END_OPEN, END_ANY} t_src_end;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b64d_in_if  src_if();
    b64d_out_if res_if();
    b64d_cfg_if cfg_if();

    int          chk_errors;
    int          chk_pending;
    int unsigned cycle_count = 0;
    int          items_sent  = 0;
    bit          src_gaps    = 1'b1;
    bit          rx_stalls   = 1'b1;
    bit          hold_long   = 1'b0;
    logic [7:0]  text_q[$];

    base64_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    base64_stream_decoder_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src     (src_if),
        .i_res     (res_if),
        .i_cfg     (cfg_if),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("base64_stream_decoder_tb: FAIL");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_long    = 1'b0;
                res_if.ready = 1'b1;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return "A" + v;
        end else if (v < 6'd52) begin
            return "a" + (v - 6'd26);
        end else if (v < b64d_pkg::SXT_PLUS) begin
            return "0" + (v - 6'd52);
        end else if (v == b64d_pkg::SXT_PLUS) begin
            return b64d_pkg::CH_PLUS;
        end
        return b64d_pkg::CH_SLASH;
    endfunction

    task automatic put_item(input logic has, input logic [7:0] ch, input logic eos);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            src_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        src_if.valid         = 1'b1;
        src_if.has_char      = has;
        src_if.in_char       = ch;
        src_if.end_of_source = eos;
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        src_if.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [b64d_pkg::LIM_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid     = 1'b1;
        cfg_if.out_limit = v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic load_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic send_text(input int noise_pct, input t_src_end how);
        logic on_char;
        int   i;
        case (how)
            END_ON_CHAR: on_char = 1'b1;
            END_ANY:     on_char = 1'($urandom_range(0, 1));
            default:     on_char = 1'b0;
        endcase
        if (text_q.size() == 0) begin
            on_char = 1'b0;
        end
        for (i = 0; i < text_q.size(); i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                if ($urandom_range(0, 2) == 0) begin
                    put_item(1'b0, 8'($urandom), 1'b0);
                end else begin
                    put_item(1'b1, ($urandom_range(0, 3) == 0) ? 8'h0A
                                   : 8'($urandom_range(128, 255)), 1'b0);
                end
            end
            put_item(1'b1, text_q[i], on_char && (i == text_q.size() - 1));
        end
        if (how == END_EMPTY || (how == END_ANY && !on_char)) begin
            put_item(1'b0, 8'($urandom), 1'b1);
        end
        text_q.delete();
    endtask

    task automatic make_encoded(input int nbytes, input bit cut);
        logic [7:0]  raw[$];
        logic [23:0] w;
        int          i;
        int          j;
        int          drop;
        for (i = 0; i < nbytes; i++) begin
            raw.push_back(8'($urandom));
        end
        for (i = 0; i < nbytes; i += 3) begin
            w = {raw[i], (i + 1 < nbytes) ? raw[i+1] : 8'h00,
                 (i + 2 < nbytes) ? raw[i+2] : 8'h00};
            for (j = 0; j < 4; j++) begin
                if ((j == 2 && i + 1 >= nbytes) || (j == 3 && i + 2 >= nbytes)) begin
                    text_q.push_back(b64d_pkg::CH_PAD);
                end else begin
                    text_q.push_back(b64_char(w[23-6*j -: 6]));
                end
            end
        end
        if (cut && text_q.size() > 0) begin
            drop = $urandom_range(1, 3);
            while (drop > 0 && text_q.size() > 0) begin
                void'(text_q.pop_back());
                drop--;
            end
        end
    endtask

    task automatic make_garbage();
        int n;
        int i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0, 1:    text_q.push_back(b64_char(6'($urandom)));
                2:       text_q.push_back(b64d_pkg::CH_PAD);
                default: text_q.push_back(8'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [b64d_pkg::LIM_W-1:0] lim;
        int                         ph;
        int                         phase_end;
        int                         pick;

        i_rst_n              = 1'b0;
        src_if.valid         = 1'b0;
        src_if.has_char      = 1'b0;
        src_if.in_char       = 8'h00;
        src_if.end_of_source = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.out_limit     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // limit still at its reset value
        load_text("TWFu");
        send_text(0, END_ON_CHAR);

        // top sextets, both pad forms, noise and empty items, partial group dropped
        load_text("+/z=");
        send_text(0, END_OPEN);
        put_item(1'b1, 8'h80, 1'b0);
        load_text("AB==");
        send_text(0, END_OPEN);
        put_item(1'b0, 8'hFF, 1'b0);
        load_text("9");
        send_text(0, END_ON_CHAR);

        settle();
        write_limit('0);
        load_text("TWFu");
        send_text(0, END_ON_CHAR);

        // limit hit inside a group on the final character
        settle();
        write_limit(b64d_pkg::LIM_W'(2));
        load_text("TWFu");
        send_text(0, END_ON_CHAR);

        // limit lowered below the count mid-source
        settle();
        write_limit(b64d_pkg::LIM_RESET);
        load_text("QUJD");
        send_text(0, END_OPEN);
        settle();
        write_limit(b64d_pkg::LIM_W'(1));
        load_text("QUJD");
        send_text(0, END_EMPTY);

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0:       lim = b64d_pkg::LIM_RESET;
                1, 4:    lim = b64d_pkg::LIM_W'($urandom_range(0, 40));
                2:       lim = b64d_pkg::LIM_W'($urandom_range(0, b64d_pkg::LIM_RESET));
                3:       lim = '0;
                default: lim = b64d_pkg::LIM_RESET;
            endcase
            write_limit(lim);
            if (ph == 5) begin
                src_gaps  = 1'b0;
                rx_stalls = 1'b0;
            end
            if (ph == 1) begin
                hold_long = 1'b1;
            end
            phase_end = items_sent + 25;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    make_encoded(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 9), 1'b0);
                    send_text(8, END_ANY);
                end else if (pick < 9) begin
                    make_garbage();
                    send_text(3, END_ANY);
                end else begin
                    make_encoded($urandom_range(1, 9), 1'b1);
                    send_text(3, END_ANY);
                end
            end
        end
        settle();

        if (chk_errors == 0 && chk_pending == 0) begin
            $display("base64_stream_decoder_tb: PASS");
        end else begin
            $display("base64_stream_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_core.sv
rtl/b64d_ser.sv
rtl/base64_stream_decoder.sv
sim/base64_stream_decoder_checker.sv
sim/base64_stream_decoder_tb.sv
